>>> rtl/core/zbd_pkg.sv
// Package for the z-buffer depth test with label update.
// Holds the payload, command and status structs and the shared codes.
// No dependencies.
package zbd_pkg;

   localparam int MAX_WIDTH_DEF     = 256;
   localparam int MAX_HEIGHT_DEF    = 256;
   localparam int MAX_TRIANGLES_DEF = 32768;
   localparam int QUEUE_DEPTH       = 2;

   localparam logic [31:0] NO_VISIBLE_DEPTH = 32'hFFFF_FFFF;
   localparam logic [15:0] NO_LABEL         = 16'hFFFF;
   localparam logic [8:0]  IMAGE_SIZE_RESET = 9'd256;

   localparam logic [1:0] FUNC_UPDATE    = 2'd0;
   localparam logic [1:0] FUNC_READ_PIX  = 2'd1;
   localparam logic [1:0] FUNC_READ_FLAG = 2'd2;

   localparam logic [2:0] ST_FIRST    = 3'd0;
   localparam logic [2:0] ST_REPLACED = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_OUTSIDE  = 3'd3;
   localparam logic [2:0] ST_READ     = 3'd4;

   localparam logic [2:0] OP_UPDATE    = 3'd0;
   localparam logic [2:0] OP_READ_PIX  = 3'd1;
   localparam logic [2:0] OP_READ_FLAG = 3'd2;
   localparam logic [2:0] OP_OUTSIDE   = 3'd3;
   localparam logic [2:0] OP_NOP       = 3'd4;

   localparam logic [1:0] CSR_LABEL_ENABLE = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd2;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [15:0] pixel_x;
      logic signed [15:0] pixel_y;
      logic signed [31:0] depth_value;
      logic [14:0]        triangle_index;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] old_depth;
      logic [15:0]        old_label;
      logic               tri_visible;
   } rsp_type;

   typedef struct packed {
      logic       label_enable;
      logic [8:0] image_width;
      logic [8:0] image_height;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         op;
      logic               tri_ok;
      logic [15:0]        x;
      logic [15:0]        y;
      logic signed [31:0] depth;
      logic [14:0]        tri_id;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic clearing;
   } back_stat_type;

endpackage

>>> rtl/core/zbuffer_depth_label_update.sv
// Top level of the z-buffer depth test with label update.
// Holds the configuration registers and joins front, queue and back.
// Depends on zbd_pkg, zbd_front, zbd_queue and zbd_back.
//
// Items enter through a queue-style push port and results leave through a
// queue-style pop port, one result per item in order. After reset the block
// sweeps its depth, label and flag stores over max(MAX_WIDTH*MAX_HEIGHT,
// min(MAX_TRIANGLES, 32768)) addresses, 65536 at the defaults, with req_full
// held high; configuration writes are taken throughout. After that an item
// passes the back-end sequencer: fetch with the registered store read,
// execute with the store write, hand-off to the result register, which
// waits while the previous result is unpopped; a replacement also clears
// the old triangle's flag via the single flag write port first. A two-entry
// command queue keeps accepting while the back end works or a result waits.
module zbuffer_depth_label_update #(
   parameter int MAX_WIDTH     = zbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = zbd_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_TRIANGLES = zbd_pkg::MAX_TRIANGLES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  zbd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output zbd_pkg::rsp_type rsp_data,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [8:0]       csr_wdata
);
   import zbd_pkg::*;

   localparam int OSW = $clog2(QUEUE_DEPTH + 3);

   cfg_type       cfg_ff, cfg_in;
   cmd_type       front_cmd;
   cmd_type       q_head;
   q_stat_type    q_stat;
   back_stat_type back_stat;
   logic          q_pop;
   logic          rsp_valid;
   logic          in_ok, out_ok;
   logic [OSW-1:0] outstanding_ff, outstanding_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_LABEL_ENABLE: cfg_in.label_enable = csr_wdata[0];
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_wdata;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_wdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
      req_full  = q_stat.full || back_stat.clearing;
      rsp_empty = !rsp_valid;
      in_ok     = req_push && !req_full;
      out_ok    = rsp_pop && !rsp_empty;
      case ({in_ok, out_ok})
         2'b10:   outstanding_in = outstanding_ff + 1'b1;
         2'b01:   outstanding_in = outstanding_ff - 1'b1;
         default: outstanding_in = outstanding_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.label_enable <= 1'b1;
         cfg_ff.image_width  <= IMAGE_SIZE_RESET;
         cfg_ff.image_height <= IMAGE_SIZE_RESET;
         outstanding_ff      <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         outstanding_ff <= outstanding_in;
      end
   end

   zbd_front #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_front (
      .cfg (cfg_ff),
      .req (req_data),
      .cmd (front_cmd)
   );

   zbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (in_ok),
      .wr_data (front_cmd),
      .pop     (q_pop),
      .rd_data (q_head),
      .q_stat  (q_stat)
   );

   zbd_back #(
      .MAX_WIDTH     (MAX_WIDTH),
      .MAX_HEIGHT    (MAX_HEIGHT),
      .MAX_TRIANGLES (MAX_TRIANGLES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .stat      (back_stat)
   );

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      back_stat.clearing |-> (rsp_empty && req_full))
      else $error("beat moved during clearing pass");

   a_outstanding_bound: assert property (@(posedge clock) disable iff (reset)
      outstanding_ff <= OSW'(QUEUE_DEPTH + 2))
      else $error("more beats in flight than the block can hold");

   a_no_invented_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (outstanding_ff != '0))
      else $error("result offered with no item in flight");

   a_pop_only_with_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("back end popped an empty queue");

endmodule

>>> rtl/core/zbd_front.sv
// Front end: classifies each input beat into a command for the back end.
// Applies the inside test and the triangle range check. Depends on zbd_pkg.
module zbd_front #(
   parameter int MAX_WIDTH     = zbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = zbd_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_TRIANGLES = zbd_pkg::MAX_TRIANGLES_DEF
) (
   input  zbd_pkg::cfg_type cfg,
   input  zbd_pkg::req_type req,
   output zbd_pkg::cmd_type cmd
);
   import zbd_pkg::*;

   logic [15:0] ux;
   logic [15:0] uy;
   logic        in_frame;

   always_comb begin
      ux = req.pixel_x;
      uy = req.pixel_y;
      in_frame = !ux[15] && !uy[15]
                 && (ux < 16'(cfg.image_width)) && (ux < 16'(MAX_WIDTH))
                 && (uy < 16'(cfg.image_height)) && (uy < 16'(MAX_HEIGHT));
      cmd.x      = ux;
      cmd.y      = uy;
      cmd.depth  = req.depth_value;
      cmd.tri_id = req.triangle_index;
      cmd.tri_ok = 32'(req.triangle_index) < 32'(MAX_TRIANGLES);
      case (req.func)
         FUNC_UPDATE: begin
            cmd.op = in_frame ? OP_UPDATE : OP_OUTSIDE;
         end
         FUNC_READ_PIX: begin
            cmd.op = in_frame ? OP_READ_PIX : OP_OUTSIDE;
         end
         FUNC_READ_FLAG: begin
            cmd.op = OP_READ_FLAG;
         end
         default: begin
            cmd.op = OP_NOP;
         end
      endcase
   end

endmodule

>>> rtl/core/zbd_queue.sv
// Short command queue between the front and back ends.
// First-word-fall-through; depends on zbd_pkg for the command struct.
module zbd_queue #(
   parameter int DEPTH = zbd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  zbd_pkg::cmd_type     wr_data,
   input  logic                 pop,
   output zbd_pkg::cmd_type     rd_data,
   output zbd_pkg::q_stat_type  q_stat
);
   import zbd_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       entry_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   always_comb begin
      q_stat.full  = count_ff == CW'(DEPTH);
      q_stat.empty = count_ff == '0;
      do_push = push && !q_stat.full;
      do_pop  = pop && !q_stat.empty;
      rd_data = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/core/zbd_back.sv
// Back end: depth, label and visible-flag stores with the read-modify-write
// sequencer, the clearing pass after reset and the result register.
// Depends on zbd_pkg.
module zbd_back #(
   parameter int MAX_WIDTH     = zbd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT    = zbd_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_TRIANGLES = zbd_pkg::MAX_TRIANGLES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  zbd_pkg::cfg_type       cfg,
   input  zbd_pkg::cmd_type       head,
   input  zbd_pkg::q_stat_type    q_stat,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_valid,
   output zbd_pkg::rsp_type       rsp_data,
   output zbd_pkg::back_stat_type stat
);
   import zbd_pkg::*;

   localparam int PIX        = MAX_WIDTH * MAX_HEIGHT;
   localparam int PIX_AW     = $clog2(PIX);
   localparam int XW         = $clog2(MAX_WIDTH);
   localparam int YW         = $clog2(MAX_HEIGHT);
   localparam int FLAG_DEPTH = (MAX_TRIANGLES < 32768) ? MAX_TRIANGLES : 32768;
   localparam int FLAG_AW    = $clog2(FLAG_DEPTH);
   localparam int SWEEP      = (PIX > FLAG_DEPTH) ? PIX : FLAG_DEPTH;
   localparam int CNT_W      = $clog2(SWEEP);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_FETCH  = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_CLROLD = 3'd3;
   localparam logic [2:0] S_DONE   = 3'd4;

   logic [31:0]  depth_mem [PIX];
   logic [15:0]  label_mem [PIX];
   logic         flag_mem  [FLAG_DEPTH];

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   cmd_type           cmd_ff, cmd_in;
   logic [PIX_AW-1:0] addr_ff, addr_in;
   rsp_type           res_ff, res_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;
   logic signed [31:0] depth_rd_ff;
   logic [15:0]       label_rd_ff;
   logic              flag_rd_ff;

   logic [PIX_AW-1:0]  head_addr;
   logic [PIX_AW-1:0]  pix_waddr;
   logic [FLAG_AW-1:0] flag_waddr;
   logic [FLAG_AW-1:0] flag_raddr;
   logic               depth_we, label_we, flag_we;
   logic [31:0]        depth_wdata;
   logic [15:0]        label_wdata;
   logic               flag_wdata;
   logic               is_empty, closer, upd, first, repl;
   logic               lbl_first, lbl_repl, old_ok;
   logic               clr_pix, clr_flag, pop_ok;

   always_comb begin
      head_addr = PIX_AW'(head.y[YW-1:0]) * PIX_AW'(MAX_WIDTH) + PIX_AW'(head.x[XW-1:0]);
      flag_raddr = head.tri_id[FLAG_AW-1:0];
      pop_ok = rsp_pop && out_valid_ff;

      is_empty  = depth_rd_ff == NO_VISIBLE_DEPTH;
      closer    = depth_rd_ff > cmd_ff.depth;
      upd       = (state_ff == S_EXEC) && (cmd_ff.op == OP_UPDATE);
      first     = upd && is_empty;
      repl      = upd && !is_empty && closer;
      lbl_first = first && cfg.label_enable && (cmd_ff.depth != NO_VISIBLE_DEPTH);
      lbl_repl  = repl && cfg.label_enable;
      old_ok    = lbl_repl && (label_rd_ff != NO_LABEL)
                  && (32'(label_rd_ff) < 32'(MAX_TRIANGLES));

      clr_pix  = (state_ff == S_CLEAR) && ((CNT_W+1)'(cnt_ff) < (CNT_W+1)'(PIX));
      clr_flag = (state_ff == S_CLEAR) && ((CNT_W+1)'(cnt_ff) < (CNT_W+1)'(FLAG_DEPTH));

      depth_we    = clr_pix || first || repl;
      label_we    = clr_pix || lbl_first || lbl_repl;
      pix_waddr   = clr_pix ? cnt_ff[PIX_AW-1:0] : addr_ff;
      depth_wdata = clr_pix ? NO_VISIBLE_DEPTH : cmd_ff.depth;
      label_wdata = clr_pix ? NO_LABEL : {1'b0, cmd_ff.tri_id};

      flag_we    = 1'b0;
      flag_waddr = cnt_ff[FLAG_AW-1:0];
      flag_wdata = 1'b0;
      if (clr_flag) begin
         flag_we = 1'b1;
      end else if ((lbl_first || lbl_repl) && cmd_ff.tri_ok) begin
         flag_we    = 1'b1;
         flag_waddr = cmd_ff.tri_id[FLAG_AW-1:0];
         flag_wdata = 1'b1;
      end else if (state_ff == S_CLROLD) begin
         flag_we    = 1'b1;
         flag_waddr = res_ff.old_label[FLAG_AW-1:0];
      end

      res_in.status      = ST_REJECTED;
      res_in.old_depth   = NO_VISIBLE_DEPTH;
      res_in.old_label   = NO_LABEL;
      res_in.tri_visible = 1'b0;
      case (cmd_ff.op)
         OP_UPDATE: begin
            res_in.old_depth = depth_rd_ff;
            res_in.old_label = label_rd_ff;
            if (is_empty) begin
               res_in.status = ST_FIRST;
            end else if (closer) begin
               res_in.status = ST_REPLACED;
            end
         end
         OP_READ_PIX: begin
            res_in.status    = ST_READ;
            res_in.old_depth = depth_rd_ff;
            res_in.old_label = label_rd_ff;
         end
         OP_READ_FLAG: begin
            res_in.status      = ST_READ;
            res_in.tri_visible = cmd_ff.tri_ok && flag_rd_ff;
         end
         OP_OUTSIDE: begin
            res_in.status = ST_OUTSIDE;
         end
         default: begin
            res_in.status = ST_REJECTED;
         end
      endcase

      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      q_pop        = 1'b0;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !pop_ok;
      case (state_ff)
         S_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SWEEP - 1)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (!q_stat.empty) begin
               q_pop    = 1'b1;
               cmd_in   = head;
               addr_in  = head_addr;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = old_ok ? S_CLROLD : S_DONE;
         end
         S_CLROLD: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!out_valid_ff || pop_ok) begin
               out_in       = res_ff;
               out_valid_in = 1'b1;
               state_in     = S_FETCH;
            end
         end
         default: begin
            state_in = S_FETCH;
         end
      endcase

      rsp_valid     = out_valid_ff;
      rsp_data      = out_ff;
      stat.clearing = state_ff == S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[pix_waddr] <= depth_wdata;
      end
      if (label_we) begin
         label_mem[pix_waddr] <= label_wdata;
      end
      if (flag_we) begin
         flag_mem[flag_waddr] <= flag_wdata;
      end
      depth_rd_ff <= depth_mem[head_addr];
      label_rd_ff <= label_mem[head_addr];
      flag_rd_ff  <= flag_mem[flag_raddr];
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      addr_ff <= addr_in;
      out_ff  <= out_in;
      if (state_ff == S_EXEC) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
